// ----- design/bpsm_pkg.sv -----
// Shared constants and types for the bit pattern stream matcher.
package bpsm_pkg;

    localparam int MAX_PATTERN_BITS = 64;
    localparam int BYTE_BITS        = 8;
    localparam int LEN_W            = $clog2(MAX_PATTERN_BITS + 1);
    localparam int POS_W            = $clog2(BYTE_BITS);
    localparam int CFG_INDEX_W      = 4;
    localparam int CFG_DATA_W       = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BITS   = 4'd0,
        REG_PATTERN_LENGTH = 4'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [MAX_PATTERN_BITS-1:0] pattern;
        logic [MAX_PATTERN_BITS-1:0] mask;
        logic [LEN_W-1:0]            length;
    } cfg_t;

    typedef struct packed {
        logic             match_here;
        logic [POS_W-1:0] match_bit;
        logic             found;
    } result_t;

endpackage

// ----- design/bpsm_cfg.sv -----
// Configuration registers: pattern, clamped length and compare mask.
module bpsm_cfg
    import bpsm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic [MAX_PATTERN_BITS-1:0] pattern_reg, pattern_next;
    logic [MAX_PATTERN_BITS-1:0] mask_reg, mask_next;
    logic [LEN_W-1:0]            length_reg, length_next;
    logic [LEN_W-1:0]            raw_len;
    logic [LEN_W-1:0]            eff_len;
    logic [LEN_W-1:0]            mask_shift;

    assign cfg_ready = 1'b1;
    assign raw_len   = cfg_data[LEN_W-1:0];

    always_comb begin
        if (raw_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (raw_len > LEN_W'(MAX_PATTERN_BITS)) begin
            eff_len = LEN_W'(MAX_PATTERN_BITS);
        end else begin
            eff_len = raw_len;
        end
        mask_shift = LEN_W'(MAX_PATTERN_BITS) - eff_len;
    end

    always_comb begin
        pattern_next = pattern_reg;
        mask_next    = mask_reg;
        length_next  = length_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_PATTERN_BITS: begin
                    pattern_next = cfg_data[MAX_PATTERN_BITS-1:0];
                end
                REG_PATTERN_LENGTH: begin
                    length_next = eff_len;
                    mask_next   = {MAX_PATTERN_BITS{1'b1}} >> mask_shift;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
            mask_reg    <= MAX_PATTERN_BITS'(1);
        end else begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
            mask_reg    <= mask_next;
        end
    end

    assign cfg.pattern = pattern_reg;
    assign cfg.mask    = mask_reg;
    assign cfg.length  = length_reg;

endmodule

// ----- design/bpsm_core.sv -----
// Bit window, bit count, sticky flag and the parallel per-bit compare.
module bpsm_core
    import bpsm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [BYTE_BITS-1:0] byte_in,
    input  cfg_t                 cfg,
    output result_t              result
);

    localparam int SEEN_SUM_W = LEN_W + 1;

    logic [MAX_PATTERN_BITS-1:0]           window_reg, window_next;
    logic [LEN_W-1:0]                      seen_reg, seen_next;
    logic                                  found_reg, found_next;
    logic [MAX_PATTERN_BITS+BYTE_BITS-1:0] joined;
    logic [BYTE_BITS-1:0]                  hit_vec;
    logic                                  any_hit;
    logic [POS_W-1:0]                      hit_pos;
    logic [SEEN_SUM_W-1:0]                 seen_sum;

    assign joined = {window_reg, byte_in};

    always_comb begin
        for (int i = 0; i < BYTE_BITS; i++) begin
            hit_vec[i] =
                (SEEN_SUM_W'(seen_reg) + SEEN_SUM_W'(i + 1) >= SEEN_SUM_W'(cfg.length)) &&
                (((joined[(BYTE_BITS-1-i) +: MAX_PATTERN_BITS] ^ cfg.pattern)
                  & cfg.mask) == '0);
        end
    end

    always_comb begin
        hit_pos = '0;
        for (int i = BYTE_BITS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_pos = POS_W'(i);
            end
        end
        any_hit = (hit_vec != '0) && !found_reg;
    end

    assign seen_sum = SEEN_SUM_W'(seen_reg) + SEEN_SUM_W'(BYTE_BITS);

    always_comb begin
        window_next = window_reg;
        seen_next   = seen_reg;
        found_next  = found_reg;
        if (advance && !found_reg) begin
            window_next = joined[MAX_PATTERN_BITS-1:0];
            seen_next   = (seen_sum > SEEN_SUM_W'(MAX_PATTERN_BITS)) ?
                          LEN_W'(MAX_PATTERN_BITS) : seen_sum[LEN_W-1:0];
            found_next  = any_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            seen_reg   <= '0;
            found_reg  <= 1'b0;
        end else begin
            window_reg <= window_next;
            seen_reg   <= seen_next;
            found_reg  <= found_next;
        end
    end

    assign result.match_here = any_hit;
    assign result.match_bit  = any_hit ? hit_pos : '0;
    assign result.found      = found_reg || any_hit;

`ifndef ASSERT_OFF
    a_found_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |=> found_reg)
        else $error("found flag cleared without reset");

    a_seen_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= LEN_W'(MAX_PATTERN_BITS))
        else $error("bit count beyond window size");

    a_no_hit_after_found: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> !result.match_here)
        else $error("second match reported");
`endif

endmodule

// ----- design/bit_pattern_stream_matcher.sv -----
// Top level: input beat register, matcher core and result register.
//
// Usage:
//   Load the pattern over the cfg channel (index 0: pattern bits, latest bit
//   at bit 0; index 1: length in cfg_data[6:0], 1..64, 0 as 1, >64 as 64).
//   Write configuration only while no beat is in flight.
//   Send stream bytes on s_valid/s_ready/s_byte_in, bits used MSB first.
//   Each input beat yields one result beat on m_valid/m_ready with
//   m_match_here, m_match_bit (0 = MSB of that byte) and sticky m_found.
//   A byte passes the input register, then the compare into the result
//   register, before its result beat is offered on m_valid.
//   Throughput: one byte per cycle unless stalled; all eight bit
//   positions compare in parallel, and the window shifts once per byte.
//   When the receiver stalls, the result register holds and the input
//   register takes one more beat; s_ready then drops until m_ready returns.
//   After the first match, later bytes give match_here 0 and found 1.
//   Reset (aresetn low, synchronous) clears the window, the bit count, the
//   found flag and both stages' valid flags; pattern 0, length 1.
module bit_pattern_stream_matcher
    import bpsm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [BYTE_BITS-1:0]   s_byte_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_match_here,
    output logic [POS_W-1:0]       m_match_bit,
    output logic                   m_found
);

    cfg_t                 cfg;
    result_t              core_result;
    logic                 in_valid_reg, in_valid_next;
    logic [BYTE_BITS-1:0] in_byte_reg, in_byte_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_result_reg, out_result_next;
    logic                 advance;

    bpsm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpsm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .byte_in (in_byte_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next   = in_valid_reg;
        in_byte_next    = in_byte_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_byte_in;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next  = 1'b1;
            out_result_next = core_result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_byte_reg    <= in_byte_next;
        out_result_reg <= out_result_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_match_here = out_result_reg.match_here;
    assign m_match_bit  = out_result_reg.match_bit;
    assign m_found      = out_result_reg.found;

`ifndef ASSERT_OFF
    a_match_implies_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_match_here) |-> m_found)
        else $error("match reported without found flag");

    a_bit_zero_without_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_match_here) |-> (m_match_bit == '0))
        else $error("match position set without a match");
`endif

endmodule
